// ===== hw/rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// request and status codes, controller states, command and status structs
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int unsigned DefTableDepth = 16;
	localparam int unsigned MaxResults    = 16;
	localparam int unsigned TimeW         = 63;
	localparam int unsigned TagW          = 16;
	localparam int unsigned HandleW       = 16;
	localparam int unsigned OrderW        = 16;
	localparam int unsigned CountW        = 5;
	localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};

	typedef enum logic [2:0] {
		REQ_SCHED_ABS = 3'd0,
		REQ_SCHED_REL = 3'd1,
		REQ_CANCEL    = 3'd2,
		REQ_ADV_ABS   = 3'd3,
		REQ_ADV_REL   = 3'd4,
		REQ_FLUSH     = 3'd5,
		REQ_UNUSED6   = 3'd6,
		REQ_UNUSED7   = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_FIRED     = 3'd2,
		ST_FLUSHED   = 3'd3,
		ST_BACKWARDS = 3'd4,
		ST_NONE_DUE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DECIDE,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_req;   // capture request
		logic    exec;       // schedule / cancel / set time
		logic    scan_start; // restart min search
		logic    scan_step;  // examine one slot
		logic    pop;        // remove found entry
		logic    load_out;   // write result register
		status_t out_status;
		logic    out_entry;  // result carries the found entry
		logic    out_last;
		logic    cap_hit;    // result cap of the run reached
	} dtq_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic backwards; // absolute advance below now
		logic full;
		logic scan_done;
		logic found;     // min entry exists
		logic found_due; // and deadline <= now
	} dtq_stat_t;

endpackage

// ===== hw/rtl/dtq_if.sv =====
// ----------------------------------------------------------------------------
// dtq_req_if / dtq_res_if: valid-ready channels of the timer queue
// request and result items with their payload
// ----------------------------------------------------------------------------
interface dtq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [62:0] time_value;
	logic [15:0] tag_value;
	logic        tag_is_scope;
	logic [15:0] handle_id;
	modport source (output valid, req_type, time_value, tag_value, tag_is_scope,
		handle_id, input ready);
	modport sink (input valid, req_type, time_value, tag_value, tag_is_scope,
		handle_id, output ready);
endinterface

interface dtq_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] out_handle;
	logic [62:0] out_deadline;
	logic [4:0]  removed_count;
	logic [62:0] next_deadline;
	logic        last_of_run;
	modport source (output valid, status, out_handle, out_deadline, removed_count,
		next_deadline, last_of_run, input ready);
	modport sink (input valid, status, out_handle, out_deadline, removed_count,
		next_deadline, last_of_run, output ready);
endinterface

// ===== hw/rtl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl: request sequencer of the timer queue
// steps each request through execute, min search and result handoff
// ----------------------------------------------------------------------------
module dtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_busy,
	input  dtq_pkg::dtq_stat_t st,
	output dtq_pkg::dtq_cmd_t  cmd
);
	import dtq_pkg::*;

	localparam int unsigned CntW = $clog2(MaxResults + 1);

	state_t state_q, state_d;
	logic [CntW-1:0] emit_q;
	logic draining;
	logic only_due;
	logic run_drain;
	logic found_ok;
	logic pop_ok;
	logic run_done;

	assign draining = (st.req == REQ_ADV_ABS) || (st.req == REQ_ADV_REL) ||
		(st.req == REQ_FLUSH);
	assign only_due = (st.req != REQ_FLUSH);
	assign run_drain = draining && !(st.req == REQ_ADV_ABS && st.backwards);
	assign found_ok = st.found && (!only_due || st.found_due);
	assign pop_ok = found_ok && (emit_q != CntW'(MaxResults));
	// the last popped item already went out marked as last of the run
	assign run_done = run_drain && (emit_q != '0) && !pop_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) emit_q <= '0;
			else if (cmd.pop) emit_q <= emit_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid && !out_busy) state_d = S_EXEC;
			S_EXEC:   state_d = S_SCAN;
			S_SCAN:   if (st.scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = S_OUT;
			S_OUT: begin
				if (run_done) state_d = S_IDLE;
				else if (!out_busy) state_d = (run_drain && pop_ok) ? S_SCAN : S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.out_status = ST_ACCEPTED;
		cmd.cap_hit = (emit_q == CntW'(MaxResults));
		in_ready = (state_q == S_IDLE) && !out_busy;
		unique case (state_q)
			S_IDLE:   cmd.load_req = in_valid && !out_busy;
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.scan_start = 1'b1;
			end
			S_SCAN:   cmd.scan_step = 1'b1;
			S_DECIDE: ;
			S_OUT: begin
				if (!run_done && !out_busy) begin
					if (run_drain) begin
						if (pop_ok) begin
							// popped entry goes out after the rescan gives its next_deadline
							cmd.pop = 1'b1;
							cmd.out_entry = 1'b1;
							cmd.out_status = only_due ? ST_FIRED : ST_FLUSHED;
							cmd.scan_start = 1'b1;
						end else begin
							cmd.load_out = 1'b1;
							cmd.out_last = 1'b1;
							cmd.out_status = only_due ? ST_NONE_DUE : ST_ACCEPTED;
						end
					end else begin
						cmd.load_out = 1'b1;
						cmd.out_last = 1'b1;
						if (st.req == REQ_ADV_ABS) cmd.out_status = ST_BACKWARDS;
						else if ((st.req == REQ_SCHED_ABS || st.req == REQ_SCHED_REL) && st.full)
							cmd.out_status = ST_FULL;
						else cmd.out_status = ST_ACCEPTED;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/dtq_dp.sv =====
// ----------------------------------------------------------------------------
// dtq_dp: timer table, time base, sequential min search and result register
// one slot examined per cycle; popped entry held until next min is known
// ----------------------------------------------------------------------------
module dtq_dp #(
	parameter int unsigned TABLE_DEPTH = dtq_pkg::DefTableDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtq_pkg::dtq_cmd_t cmd,
	output dtq_pkg::dtq_stat_t st,
	input  logic [2:0]        req_type,
	input  logic [62:0]       time_value,
	input  logic [15:0]       tag_value,
	input  logic              tag_is_scope,
	input  logic [15:0]       handle_id,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [2:0]        res_status,
	output logic [15:0]       res_handle,
	output logic [62:0]       res_deadline,
	output logic [4:0]        res_removed,
	output logic [62:0]       res_next,
	output logic              res_last
);
	import dtq_pkg::*;

	localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TimeW-1:0]   dl_q   [TABLE_DEPTH];
	logic [TagW-1:0]    tag_q  [TABLE_DEPTH];
	logic               kind_q [TABLE_DEPTH];
	logic [HandleW-1:0] hdl_q  [TABLE_DEPTH];
	logic [OrderW-1:0]  ord_q  [TABLE_DEPTH];
	logic [TimeW-1:0]   now_q;
	logic [OrderW-1:0]  ins_q;

	req_t             req_q;
	logic [TimeW-1:0] tv_q;
	logic [TagW-1:0]  tag_rq;
	logic             kind_rq;
	logic [HandleW-1:0] hid_q;

	// outcome of the execute step, kept for the result
	logic              full_q;
	logic [CountW-1:0] rm_q;

	// free slot and cancel matches
	logic [IdxW-1:0] free_idx;
	logic            full;
	always_comb begin
		free_idx = '0;
		full = 1'b1;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				full = 1'b0;
			end
		end
	end

	logic [TABLE_DEPTH-1:0] match;
	logic [CntW-1:0] match_cnt;
	always_comb begin
		match_cnt = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && kind_q[i] == kind_rq && tag_q[i] == tag_rq &&
				!(kind_rq && tag_rq == '0);
			match_cnt = match_cnt + CntW'(match[i]);
		end
	end

	logic [TimeW:0] rel_sum;
	logic [TimeW-1:0] rel_sat;
	assign rel_sum = {1'b0, now_q} + {1'b0, tv_q};
	assign rel_sat = rel_sum[TimeW] ? TimeMax : rel_sum[TimeW-1:0];

	// min search
	logic [IdxW-1:0] scan_q;
	logic [CntW-1:0] scan_n_q;
	logic            best_v_q;
	logic [IdxW-1:0] best_q;
	logic [TimeW-1:0] best_dl_q;
	logic [OrderW-1:0] best_age_q;
	logic [OrderW-1:0] cur_age;
	logic cand_better;
	assign cur_age = ins_q - ord_q[scan_q];
	assign cand_better = valid_q[scan_q] && (!best_v_q || dl_q[scan_q] < best_dl_q ||
		(dl_q[scan_q] == best_dl_q && cur_age > best_age_q));

	assign st.req = req_q;
	assign st.backwards = tv_q < now_q;
	assign st.full = full_q;
	assign st.scan_done = (scan_n_q == CntW'(TABLE_DEPTH - 1)) && cmd.scan_step;
	assign st.found = best_v_q;
	assign st.found_due = best_dl_q <= now_q;

	// popped entry waiting for its next_deadline
	logic pend_q;
	status_t pend_st_q;
	logic [HandleW-1:0] pend_h_q;
	logic [TimeW-1:0]  pend_d_q;

	// minimum over the table at the last scan step
	logic             next_v;
	logic [TimeW-1:0] next_dl;
	logic             more_due;
	assign next_v = best_v_q || cand_better;
	assign next_dl = cand_better ? dl_q[scan_q] : best_dl_q;
	assign more_due = next_v && (pend_st_q == ST_FLUSHED || next_dl <= now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			now_q     <= '0;
			ins_q     <= '0;
			res_valid <= 1'b0;
			pend_q    <= 1'b0;
			best_v_q  <= 1'b0;
			scan_q    <= '0;
			scan_n_q  <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (cmd.load_req) begin
				req_q   <= req_t'(req_type);
				tv_q    <= time_value;
				tag_rq  <= tag_value;
				kind_rq <= tag_is_scope;
				hid_q   <= handle_id;
			end
			if (cmd.exec) begin
				full_q <= full;
				rm_q   <= (req_q != REQ_CANCEL) ? '0 :
					((int'(match_cnt) > 31) ? CountW'(31) : CountW'(match_cnt));
				unique case (req_q)
					REQ_SCHED_ABS, REQ_SCHED_REL: if (!full) begin
						valid_q[free_idx] <= 1'b1;
						dl_q[free_idx]    <= (req_q == REQ_SCHED_ABS) ? tv_q : rel_sat;
						tag_q[free_idx]   <= tag_rq;
						kind_q[free_idx]  <= kind_rq;
						hdl_q[free_idx]   <= hid_q;
						ord_q[free_idx]   <= ins_q;
						ins_q <= ins_q + 1'b1;
					end
					REQ_CANCEL: valid_q <= valid_q & ~match;
					REQ_ADV_ABS: if (!(tv_q < now_q)) now_q <= tv_q;
					REQ_ADV_REL: now_q <= rel_sat;
					REQ_FLUSH:   now_q <= tv_q;
					default: ;
				endcase
			end
			if (cmd.pop) begin
				valid_q[best_q] <= 1'b0;
				pend_q    <= 1'b1;
				pend_st_q <= cmd.out_status;
				pend_h_q  <= hdl_q[best_q];
				pend_d_q  <= best_dl_q;
			end
			if (cmd.scan_start) begin
				scan_q   <= '0;
				scan_n_q <= '0;
				best_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q   <= (scan_n_q == CntW'(TABLE_DEPTH - 1)) ? scan_q : scan_q + 1'b1;
				scan_n_q <= scan_n_q + 1'b1;
				if (cand_better) begin
					best_v_q   <= 1'b1;
					best_q     <= scan_q;
					best_dl_q  <= dl_q[scan_q];
					best_age_q <= cur_age;
				end
			end
			// a popped entry is emitted once the rescan that follows it is done
			if (pend_q && st.scan_done) begin
				pend_q      <= 1'b0;
				res_valid   <= 1'b1;
				res_status  <= pend_st_q;
				res_handle  <= pend_h_q;
				res_deadline <= pend_d_q;
				res_removed <= '0;
				res_next    <= next_v ? next_dl : TimeMax;
				res_last    <= cmd.cap_hit || !more_due;
			end else if (cmd.load_out) begin
				res_valid   <= 1'b1;
				res_status  <= cmd.out_status;
				res_handle  <= '0;
				res_deadline <= '0;
				res_removed <= rm_q;
				res_next    <= best_v_q ? best_dl_q : TimeMax;
				res_last    <= cmd.out_last;
			end
		end
	end
endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue: table of pending timers with cancel, advance and flush
// controller sequences each request over a slot-serial minimum search
// ----------------------------------------------------------------------------
// each request is executed, then the table is scanned for its minimum; a
// non-draining request gets a single result, each fired or flushed item is
// popped and sent once a rescan gives its next_deadline; the single
// comparator walks the table one slot a cycle; one request at a time, input
// taken only when the previous run is done and its last result has left
// reset empties the table, clears current time and insertion counter
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
	parameter int unsigned TABLE_DEPTH = dtq_pkg::DefTableDepth
) (
	input logic  clk,
	input logic  arst_n,
	dtq_req_if.sink   req,
	dtq_res_if.source res
);
	import dtq_pkg::*;

	dtq_cmd_t  cmd;
	dtq_stat_t st;
	logic      out_busy;

	// busy while the result register holds an item that is not yet taken
	assign out_busy = res.valid && !res.ready;

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_busy (out_busy),
		.st       (st),
		.cmd      (cmd)
	);

	dtq_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.req_type     (req.req_type),
		.time_value   (req.time_value),
		.tag_value    (req.tag_value),
		.tag_is_scope (req.tag_is_scope),
		.handle_id    (req.handle_id),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.res_status   (res.status),
		.res_handle   (res.out_handle),
		.res_deadline (res.out_deadline),
		.res_removed  (res.removed_count),
		.res_next     (res.next_deadline),
		.res_last     (res.last_of_run)
	);

	// a request is never taken while a result is still on its way
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !res.valid || res.ready)
		else $error("request taken with result pending");

	// command exclusivity between pop and result load
	a_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && cmd.load_out))
		else $error("pop and load in one cycle");

	// fired and flushed items carry a deadline not after the result's next deadline
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == ST_FIRED || res.status == ST_FLUSHED) |->
		res.out_deadline <= res.next_deadline)
		else $error("fired out of order");
endmodule
